/* sv/rtip_pkg.sv */
`timescale 1ns / 1ps

package rtip_pkg;

	localparam int MaxChars = 4096;
	localparam int CharIdxW = $clog2(MaxChars);
	localparam int PosW     = 12;
	localparam int CpW      = 21;
	localparam int BaseW    = 6;
	localparam int DigitW   = 6;
	localparam int ValueW   = 64;
	localparam int ProdW    = ValueW + BaseW + 1;

	localparam logic [CpW-1:0] SignPlus   = CpW'(32'h002b);
	localparam logic [CpW-1:0] SignHyphen = CpW'(32'h002d);
	localparam logic [CpW-1:0] SignMinus  = CpW'(32'h2212);

	localparam logic [BaseW-1:0] BaseReset = BaseW'(10);
	localparam logic [BaseW-1:0] BaseMin   = BaseW'(2);
	localparam logic [BaseW-1:0] BaseMax   = BaseW'(36);

	// Digit code for a character that is no digit at all; never below a legal radix.
	localparam logic [DigitW-1:0] NoDigit = DigitW'(36);

	typedef enum logic [2:0] {
		StOk            = 3'd0,
		StEmpty         = 3'd1,
		StDoubleSpace   = 3'd2,
		StIllegal       = 3'd3,
		StOverflow      = 3'd4,
		StTrailingSpace = 3'd5,
		StNoDigits      = 3'd6
	} status_t;

	typedef struct packed {
		logic              is_space;
		logic              is_plus;
		logic              is_minus;
		logic [DigitW-1:0] digit;
	} char_class_t;

	typedef struct packed {
		logic              valid;
		logic [ValueW-1:0] value;
		status_t           status;
		logic [PosW-1:0]   position;
	} result_t;

endpackage

/* sv/radix_text_to_int64_parser.sv */
`timescale 1ns / 1ps

// Streaming text-to-integer converter. Each item on the char channel is one
// Unicode code point; the item with last_char set closes the string and
// yields exactly one item on the result channel, carrying the signed 64-bit
// value, a status code and the index of the first error. The block takes one
// character every cycle unless a last character waits on the result
// register: an input register feeds the combinational classification, a 64x6
// multiply-add with its range check and the state update, and a result
// register holds the answer. The parse state loops back through that logic,
// so a character may follow the previous one with no gap. The result of a
// last character passes from the input register to the result register,
// where it can be taken. A result that is not taken stalls only a following last character;
// ordinary characters keep flowing. The radix register accepts a write in any
// cycle and should only be changed between strings.

module radix_text_to_int64_parser (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rtip_pkg::BaseW-1:0]   number_base,

	input  logic                         char_valid,
	output logic                         char_ready,
	input  logic [rtip_pkg::CpW-1:0]     code_point,
	input  logic                         last_char,
	input  logic                         empty_text,

	output logic                         result_valid,
	input  logic                         result_ready,
	output logic signed [rtip_pkg::ValueW-1:0] parsed_value,
	output logic [2:0]                   status,
	output logic [rtip_pkg::PosW-1:0]    error_position
);

	// Radix register.
	logic [rtip_pkg::BaseW-1:0] base_q;

	// Input register stage.
	logic                     valid_s1;
	logic [rtip_pkg::CpW-1:0] cp_s1;
	logic                     last_s1;
	logic                     empty_s1;

	// Result register.
	logic                        res_valid_q;
	logic [rtip_pkg::ValueW-1:0] res_value_q;
	rtip_pkg::status_t           res_status_q;
	logic [rtip_pkg::PosW-1:0]   res_pos_q;

	rtip_pkg::char_class_t cls;
	rtip_pkg::result_t     result;
	logic                  out_free;
	logic                  advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= rtip_pkg::BaseReset;
		end else if (cfg_valid) begin
			base_q <= number_base;
		end
	end

	// The staged item moves on unless it closes a string while the result
	// register still holds an answer that nobody has taken.
	assign out_free   = !res_valid_q || result_ready;
	assign advance    = valid_s1 && (!last_s1 || out_free);
	assign char_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			cp_s1    <= code_point;
			last_s1  <= last_char;
			empty_s1 <= empty_text;
		end
	end

	rtip_char_class u_char_class (
		.code_point (cp_s1),
		.cls        (cls)
	);

	rtip_parse_core u_parse_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.cls         (cls),
		.last_char   (last_s1),
		.empty_text  (empty_s1),
		.number_base (base_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && result.valid) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			res_value_q  <= result.value;
			res_status_q <= result.status;
			res_pos_q    <= result.position;
		end
	end

	assign result_valid   = res_valid_q;
	assign parsed_value   = res_value_q;
	assign status         = res_status_q;
	assign error_position = res_pos_q;

endmodule

/* sv/rtip_char_class.sv */
`timescale 1ns / 1ps

module rtip_char_class (
	input  logic [rtip_pkg::CpW-1:0] code_point,
	output rtip_pkg::char_class_t    cls
);

	logic [rtip_pkg::CpW-1:0] cp;

	assign cp = code_point;

	always_comb begin
		cls.is_plus  = (cp == rtip_pkg::SignPlus);
		cls.is_minus = (cp == rtip_pkg::SignHyphen) || (cp == rtip_pkg::SignMinus);

		// Unicode space separators (Zs).
		cls.is_space = (cp == rtip_pkg::CpW'(32'h0020)) ||
		               (cp == rtip_pkg::CpW'(32'h00a0)) ||
		               (cp == rtip_pkg::CpW'(32'h1680)) ||
		               ((cp >= rtip_pkg::CpW'(32'h2000)) &&
		                (cp <= rtip_pkg::CpW'(32'h200a))) ||
		               (cp == rtip_pkg::CpW'(32'h202f)) ||
		               (cp == rtip_pkg::CpW'(32'h205f)) ||
		               (cp == rtip_pkg::CpW'(32'h3000));

		if ((cp >= rtip_pkg::CpW'(32'h30)) && (cp <= rtip_pkg::CpW'(32'h39))) begin
			cls.digit = rtip_pkg::DigitW'(cp - rtip_pkg::CpW'(32'h30));
		end else if ((cp >= rtip_pkg::CpW'(32'h61)) && (cp <= rtip_pkg::CpW'(32'h7a))) begin
			cls.digit = rtip_pkg::DigitW'(cp - rtip_pkg::CpW'(32'h61) + rtip_pkg::CpW'(10));
		end else if ((cp >= rtip_pkg::CpW'(32'h41)) && (cp <= rtip_pkg::CpW'(32'h5a))) begin
			cls.digit = rtip_pkg::DigitW'(cp - rtip_pkg::CpW'(32'h41) + rtip_pkg::CpW'(10));
		end else begin
			cls.digit = rtip_pkg::NoDigit;
		end
	end

endmodule

/* sv/rtip_parse_core.sv */
`timescale 1ns / 1ps

module rtip_parse_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  rtip_pkg::char_class_t      cls,
	input  logic                       last_char,
	input  logic                       empty_text,
	input  logic [rtip_pkg::BaseW-1:0] number_base,
	output rtip_pkg::result_t          result
);

	logic [rtip_pkg::ValueW-1:0]   acc_q, acc_d;
	logic                          neg_q, neg_d;
	logic                          space_q, space_d;
	logic                          seen_q, seen_d;
	logic [rtip_pkg::CharIdxW-1:0] idx_q, idx_d;
	rtip_pkg::status_t             err_q, err_d;
	logic [rtip_pkg::PosW-1:0]     eidx_q, eidx_d;

	logic [rtip_pkg::BaseW-1:0]    base;
	logic [rtip_pkg::ProdW-1:0]    prod;
	logic [rtip_pkg::ProdW-1:0]    limit;
	logic [rtip_pkg::PosW-1:0]     pos;
	logic                          first;

	always_comb begin
		if (number_base < rtip_pkg::BaseMin) begin
			base = rtip_pkg::BaseMin;
		end else if (number_base > rtip_pkg::BaseMax) begin
			base = rtip_pkg::BaseMax;
		end else begin
			base = number_base;
		end
	end

	// The full product is compared with the limit, so no division is needed.
	assign prod  = rtip_pkg::ProdW'(acc_q) * rtip_pkg::ProdW'(base) +
	               rtip_pkg::ProdW'(cls.digit);
	assign limit = (rtip_pkg::ProdW'(1) << (rtip_pkg::ValueW - 1)) -
	               rtip_pkg::ProdW'(!neg_q);
	assign pos   = rtip_pkg::PosW'(idx_q);
	assign first = (idx_q == '0);

	always_comb begin
		acc_d   = acc_q;
		neg_d   = neg_q;
		space_d = space_q;
		seen_d  = seen_q;
		idx_d   = idx_q;
		err_d   = err_q;
		eidx_d  = eidx_q;

		result.valid    = 1'b0;
		result.value    = '0;
		result.status   = rtip_pkg::StOk;
		result.position = '0;

		if (empty_text) begin
			if (last_char) begin
				result.valid  = 1'b1;
				result.status = rtip_pkg::StEmpty;
			end
		end else begin
			if (err_q == rtip_pkg::StOk) begin
				if (first && cls.is_minus) begin
					neg_d = 1'b1;
				end else if (first && cls.is_plus) begin
					neg_d = neg_q;
				end else if (!first && cls.is_space) begin
					if (space_q) begin
						err_d  = rtip_pkg::StDoubleSpace;
						eidx_d = pos;
					end else begin
						space_d = 1'b1;
					end
				end else if (cls.digit >= base) begin
					err_d  = rtip_pkg::StIllegal;
					eidx_d = pos;
				end else if (prod > limit) begin
					err_d  = rtip_pkg::StOverflow;
					eidx_d = pos;
				end else begin
					acc_d   = prod[rtip_pkg::ValueW-1:0];
					space_d = 1'b0;
					seen_d  = 1'b1;
				end
			end

			if (!last_char) begin
				if (idx_q < rtip_pkg::CharIdxW'(rtip_pkg::MaxChars - 1)) begin
					idx_d = idx_q + rtip_pkg::CharIdxW'(1);
				end
			end else begin
				if (space_d && err_d == rtip_pkg::StOk) begin
					err_d  = rtip_pkg::StTrailingSpace;
					eidx_d = pos;
				end
				if (!seen_d && err_d == rtip_pkg::StOk) begin
					err_d  = rtip_pkg::StNoDigits;
					eidx_d = pos;
				end
				result.valid = 1'b1;
				if (err_d != rtip_pkg::StOk) begin
					result.status   = err_d;
					result.position = eidx_d;
				end else begin
					result.value = neg_d ? (rtip_pkg::ValueW'(0) - acc_d) : acc_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			space_q <= 1'b0;
			seen_q  <= 1'b0;
			idx_q   <= '0;
			err_q   <= rtip_pkg::StOk;
			eidx_q  <= '0;
		end else if (step) begin
			if (result.valid) begin
				acc_q   <= '0;
				neg_q   <= 1'b0;
				space_q <= 1'b0;
				seen_q  <= 1'b0;
				idx_q   <= '0;
				err_q   <= rtip_pkg::StOk;
				eidx_q  <= '0;
			end else begin
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				space_q <= space_d;
				seen_q  <= seen_d;
				idx_q   <= idx_d;
				err_q   <= err_d;
				eidx_q  <= eidx_d;
			end
		end
	end

endmodule

/* sim/radix_text_to_int64_parser_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the radix text parser. Strings go in one code point
// per item. A model of the parse state in this module turns every accepted item
// into zero or one expected result. A monitor compares each accepted result with
// the oldest expected one, field by field. The radix register is only rewritten
// once every expected result has come back and the pipeline has had time to
// settle.

module radix_text_to_int64_parser_tb;

	import rtip_pkg::*;

	localparam int unsigned MaxCodePoint   = 1114111;
	localparam int unsigned ItemsPerPhase  = 40;
	localparam int unsigned LongRun        = 50;
	localparam int unsigned DrainCycles    = 8;
	localparam int unsigned StallLimit     = 2000;

	// The space separators of the Zs category, and the three leading signs.
	localparam logic [CpW-1:0] SpaceCodes [17] = '{
		21'h0020, 21'h00a0, 21'h1680, 21'h2000, 21'h2001, 21'h2002, 21'h2003, 21'h2004,
		21'h2005, 21'h2006, 21'h2007, 21'h2008, 21'h2009, 21'h200a, 21'h202f, 21'h205f,
		21'h3000
	};
	localparam logic [CpW-1:0] SignCodes [3] = '{SignPlus, SignHyphen, SignMinus};

	typedef struct {
		logic signed [ValueW-1:0] value;
		status_t                  status;
		logic [PosW-1:0]          pos;
	} parse_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [BaseW-1:0]          number_base;
	logic                      char_valid;
	logic                      char_ready;
	logic [CpW-1:0]            code_point;
	logic                      last_char;
	logic                      empty_text;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	logic signed [ValueW-1:0]  parsed_value;
	logic [2:0]                status;
	logic [PosW-1:0]           error_position;

	// Model of the parse state. It is updated only by the monitor, at the
	// clock edge where an item is accepted.
	logic [BaseW-1:0]  radix_reg  = BaseReset;
	logic [ValueW-1:0] magnitude  = '0;
	logic              negative   = 1'b0;
	logic              gap_seen   = 1'b0;
	logic              digit_seen = 1'b0;
	logic [PosW-1:0]   char_idx   = '0;
	status_t           err_code   = StOk;
	logic [PosW-1:0]   err_pos    = '0;

	parse_result_t pending_results[$];
	int unsigned   fail_count = 0;

	// Stimulus side state. While steady is set, neither side of the block idles.
	bit             steady = 1'b0;
	bit             cut_text = 1'b0;
	int unsigned    sent_count = 0;
	int unsigned    text_radix = 10;
	logic [CpW-1:0] text_buf[$];

	radix_text_to_int64_parser u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.number_base    (number_base),
		.char_valid     (char_valid),
		.char_ready     (char_ready),
		.code_point     (code_point),
		.last_char      (last_char),
		.empty_text     (empty_text),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.parsed_value   (parsed_value),
		.status         (status),
		.error_position (error_position)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The result side stalls at random, except during a steady stretch.
	always @(posedge clk) begin
		result_ready <= steady || ($urandom_range(99) >= 16);
	end

	// ------------------------------------------------------------------
	// Parse model
	// ------------------------------------------------------------------

	function automatic void clear_text();
		magnitude  = '0;
		negative   = 1'b0;
		gap_seen   = 1'b0;
		digit_seen = 1'b0;
		char_idx   = '0;
		err_code   = StOk;
		err_pos    = '0;
	endfunction

	// Only the first error of a string is kept.
	function automatic void flag_error(status_t code, logic [PosW-1:0] where);
		if (err_code == StOk) begin
			err_code = code;
			err_pos  = where;
		end
	endfunction

	// Advances the model by one accepted item. Returns 1 when the item closes
	// a string, with the expected result in res.
	function automatic bit parse_char(logic [CpW-1:0] cp, bit last, bit empty,
			output parse_result_t res);
		logic [PosW-1:0]   idx;
		logic [ValueW-1:0] radix;
		logic [ValueW-1:0] dval;
		logic [ValueW-1:0] limit;
		bit                is_space;
		idx = char_idx;
		res.value  = '0;
		res.status = StOk;
		res.pos    = '0;
		if (empty) begin
			// An empty string drops whatever came before it; without the last
			// flag the item is simply ignored.
			if (!last)
				return 1'b0;
			res.status = StEmpty;
			clear_text();
			return 1'b1;
		end
		is_space = 1'b0;
		foreach (SpaceCodes[i])
			if (cp == SpaceCodes[i])
				is_space = 1'b1;
		if (err_code == StOk) begin
			if (idx == 0 && (cp == SignHyphen || cp == SignMinus)) begin
				negative = 1'b1;
			end else if (idx == 0 && cp == SignPlus) begin
				// A plus sign changes nothing.
			end else if (idx != 0 && is_space) begin
				if (gap_seen)
					flag_error(StDoubleSpace, idx);
				else
					gap_seen = 1'b1;
			end else begin
				if (radix_reg < BaseMin)
					radix = BaseMin;
				else if (radix_reg > BaseMax)
					radix = BaseMax;
				else
					radix = radix_reg;
				if (cp >= 21'h30 && cp <= 21'h39)
					dval = cp - 21'h30;
				else if (cp >= 21'h61 && cp <= 21'h7a)
					dval = cp - 21'h61 + 10;
				else if (cp >= 21'h41 && cp <= 21'h5a)
					dval = cp - 21'h41 + 10;
				else
					dval = NoDigit;
				if (dval >= radix) begin
					flag_error(StIllegal, idx);
				end else begin
					// A negative value may reach 2^63 in magnitude, a positive one
					// stops at 2^63 - 1.
					limit = negative ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
					if (magnitude > (limit - dval) / radix) begin
						flag_error(StOverflow, idx);
					end else begin
						magnitude  = magnitude * radix + dval;
						gap_seen   = 1'b0;
						digit_seen = 1'b1;
					end
				end
			end
		end
		if (!last) begin
			// The index sticks at its top value on very long strings.
			if (idx < MaxChars - 1)
				char_idx = idx + 1'b1;
			return 1'b0;
		end
		if (gap_seen)
			flag_error(StTrailingSpace, idx);
		if (!digit_seen)
			flag_error(StNoDigits, idx);
		if (err_code != StOk) begin
			res.status = err_code;
			res.pos    = err_pos;
		end else begin
			res.value = negative ? (64'd0 - magnitude) : magnitude;
		end
		clear_text();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: follows the register writes, feeds accepted items to the model
	// and checks every result that leaves the block.
	// ------------------------------------------------------------------

	always @(posedge clk) begin : monitor
		parse_result_t want;
		parse_result_t got;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with no expectation waiting: value %0d status %0d position %0d",
						parsed_value, status, error_position);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (parsed_value !== want.value) begin
						$error("parsed_value: expected %0d, got %0d", want.value, parsed_value);
						fail_count++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
					if (error_position !== want.pos) begin
						$error("error_position: expected %0d, got %0d", want.pos,
							error_position);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				radix_reg = number_base;
			if (char_valid && char_ready)
				if (parse_char(code_point, last_char, empty_text, got))
					pending_results.push_back(got);
		end
	end

	// Ends the run when no channel has moved for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if (!arst_n || (char_valid && char_ready) || (result_valid && result_ready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [CpW-1:0] pick_space();
		return SpaceCodes[$urandom_range(16)];
	endfunction

	// Letters come out in either case at random.
	function automatic logic [CpW-1:0] digit_char(int unsigned d);
		if (d < 10)
			return CpW'(21'h30 + d);
		return CpW'(($urandom_range(1) ? 21'h61 : 21'h41) + d - 10);
	endfunction

	// Sends one item. The valid line is only lowered when the sender idles, so
	// back-to-back items keep it high.
	task automatic send_char(logic [CpW-1:0] cp, bit last, bit empty);
		int unsigned gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(99) < 16)
				gap++;
		if (gap != 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		code_point <= cp;
		last_char  <= last;
		empty_text <= empty;
		do @(posedge clk); while (!char_ready);
		if (!empty || last)
			sent_count++;
	endtask

	// Sends text_buf as one string. Ignored empty items are sprinkled in, and
	// with cut_text set the string is closed by an empty item instead.
	task automatic send_text();
		foreach (text_buf[i]) begin
			if ($urandom_range(19) == 0)
				send_char(CpW'($urandom_range(MaxCodePoint)), 1'b0, 1'b1);
			send_char(text_buf[i], !cut_text && i == text_buf.size() - 1, 1'b0);
		end
		if (cut_text || text_buf.size() == 0)
			send_char(CpW'($urandom_range(MaxCodePoint)), 1'b1, 1'b1);
	endtask

	task automatic send_string(string s);
		text_buf.delete();
		foreach (s[i])
			text_buf.push_back(CpW'(s[i]));
		send_text();
	endtask

	// Appends the digits of mag in the given radix, after some leading zeros,
	// with single separators between digits now and then.
	task automatic spell_number(logic [ValueW-1:0] mag, int unsigned radix,
			int unsigned zeros, bit spaced);
		logic [CpW-1:0] digits[$];
		do begin
			digits.push_front(digit_char(int'(mag % radix)));
			mag = mag / radix;
		end while (mag != 0);
		repeat (zeros) digits.push_front(21'h30);
		foreach (digits[i]) begin
			if (i != 0 && spaced && $urandom_range(4) == 0)
				text_buf.push_back(pick_space());
			text_buf.push_back(digits[i]);
		end
	endtask

	// Waits until every expected result is in and the pipeline has gone
	// quiet, since an ignored item may still be in flight.
	task automatic wait_drained();
		char_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_radix(logic [BaseW-1:0] value);
		wait_drained();
		cfg_valid   <= 1'b1;
		number_base <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed numbers with random sign, size and separators; the
	// rest are broken in one of several ways.
	task automatic random_text();
		logic [ValueW-1:0] mag;
		int unsigned       pos;
		text_buf.delete();
		cut_text = 1'b0;
		case ($urandom_range(3))
			1: text_buf.push_back(SignPlus);
			2: text_buf.push_back(SignHyphen);
			3: text_buf.push_back(SignMinus);
			default: ;
		endcase
		if ($urandom_range(9) == 0)
			mag = 64'h7fff_ffff_ffff_ffff + $urandom_range(2);
		else
			mag = {$urandom, $urandom} >> $urandom_range(63);
		spell_number(mag, text_radix, $urandom_range(2), 1'b1);
		if ($urandom_range(99) < 30) begin
			pos = $urandom_range(text_buf.size() - 1);
			case ($urandom_range(7))
				0: begin
					pos = $urandom_range(1, text_buf.size());
					text_buf.insert(pos, pick_space());
					text_buf.insert(pos, pick_space());
				end
				1: text_buf.push_back(pick_space());
				2: text_buf[pos] = CpW'($urandom_range(MaxCodePoint));
				3: text_buf[pos] = (text_radix < 36) ?
						digit_char($urandom_range(text_radix, 35)) : CpW'(21'h2e);
				4: text_buf.push_front(pick_space());
				5: begin
					// A sign and no digits, now and then followed by a space.
					text_buf.delete();
					text_buf.push_back(SignCodes[$urandom_range(2)]);
					if ($urandom_range(1))
						text_buf.push_back(pick_space());
				end
				6: begin
					if ($urandom_range(1))
						text_buf.delete();
					else
						cut_text = 1'b1;
				end
				default: begin
					text_buf.delete();
					repeat ($urandom_range(1, 6))
						text_buf.push_back(CpW'($urandom_range(MaxCodePoint)));
				end
			endcase
		end
		send_text();
		cut_text = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Short strings at the reset radix: signs, separators and every status but overflow.
	task automatic test_basic_strings();
		send_string("+7");
		text_buf = '{SignMinus, 21'h35};
		send_text();
		send_string("-");
		text_buf = '{21'h31, 21'h3000, 21'h32};
		send_text();
		send_string("1  2");
		send_string("1 ");
		send_string(" 1");
		send_string("a");
		send_string("Zz");
		text_buf.delete();
		send_text();
		// An ignored empty item in the middle of a string.
		send_char(21'h34, 1'b0, 1'b0);
		send_char(21'h10_ffff, 1'b0, 1'b1);
		send_char(21'h32, 1'b1, 1'b0);
		// A string closed by an empty item is reported as empty.
		text_buf = '{21'h39};
		cut_text = 1'b1;
		send_text();
		cut_text = 1'b0;
		text_buf = '{21'h10_ffff};
		send_text();
		send_string("x  1");
		send_string("1 2  3x");
	endtask

	// The edges of the 64-bit range for both signs, in radix 10 and 36.
	task automatic test_value_limits();
		logic [ValueW-1:0] mags[5];
		bit                negs[5];
		int unsigned       radix;
		mags = '{64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
			64'h8000_0000_0000_0001, 64'hffff_ffff_ffff_ffff};
		negs = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
		for (int k = 0; k < 2; k++) begin
			radix = (k == 0) ? 10 : 36;
			set_radix(BaseW'(radix));
			foreach (mags[i]) begin
				text_buf.delete();
				if (negs[i])
					text_buf.push_back(SignHyphen);
				spell_number(mags[i], radix, 0, 1'b1);
				send_text();
			end
		end
	endtask

	// Long strings: an error found far into the text keeps its exact index.
	task automatic test_long_text();
		repeat (LongRun) send_char(21'h30, 1'b0, 1'b0);
		send_char(21'h21, 1'b1, 1'b0);
		repeat (LongRun) send_char(21'h31, 1'b0, 1'b0);
		send_char(pick_space(), 1'b1, 1'b0);
	endtask

	// Random strings over several radix settings, out-of-range ones among
	// them. One phase runs with no idling on either side.
	task automatic test_random_strings();
		logic [BaseW-1:0] radix_plan[10];
		int unsigned      start;
		radix_plan = '{6'd2, 6'd36, 6'd16, 6'd0, 6'd63, 6'd1, 6'd37, 6'd8,
			BaseW'($urandom_range(2, 36)), BaseReset};
		foreach (radix_plan[p]) begin
			set_radix(radix_plan[p]);
			if (radix_plan[p] < BaseMin)
				text_radix = BaseMin;
			else if (radix_plan[p] > BaseMax)
				text_radix = BaseMax;
			else
				text_radix = radix_plan[p];
			steady = (p == 8);
			start = sent_count;
			while (sent_count - start < ItemsPerPhase)
				random_text();
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		number_base = BaseReset;
		char_valid  = 1'b0;
		code_point  = '0;
		last_char   = 1'b0;
		empty_text  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_strings();
		test_value_limits();
		test_long_text();
		test_random_strings();
		wait_drained();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
sv/rtip_pkg.sv
sv/rtip_char_class.sv
sv/rtip_parse_core.sv
sv/radix_text_to_int64_parser.sv
sim/radix_text_to_int64_parser_tb.sv
